>>> rtl/csh_pkg.sv
// Shared constants and types for the chunked string hash.
package csh_pkg;

  localparam logic [63:0] GOLDEN_MUL = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SEED_SUB   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] FMIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_MUL_B = 64'hc4ceb9fe1a85ec53;
  localparam int MIX_SHIFT   = 31;
  localparam int FMIX_SHIFT  = 33;
  localparam int CHUNK_BYTES = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [63:0] chunk;
    logic        mix;
    logic        first;
    logic        last;
    logic [63:0] seed;
  } op_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

endpackage

>>> rtl/chunked_string_hash_64.sv
// Top level of the chunked string hash: input stage, queue, hash engine, multiplier.
//
// Chunks of a string enter as little-endian 8-byte words; a chunk marked first
// loads both lanes from its seed, and a chunk marked last yields one hash_value
// transfer. A chunk with at least one byte occupies the hash engine to issue a
// multiply, to build the 64-bit product from three partial products on a single
// shared 32x32 multiplier, and to fold it into the lanes. A zero-byte chunk that
// is not last needs no product. The last chunk adds the cross-add and four more
// products of the finalizer on the same multiplier. A two-entry queue ahead of
// the engine keeps taking chunks while the engine works or a result waits at
// the output.
module chunked_string_hash_64 import csh_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] chunk_bytes,
  input  logic [3:0]  byte_count,
  input  logic        first,
  input  logic        last,
  input  logic [63:0] seed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);

  logic     f_valid;
  logic     q_in_ready;
  op_t      f_op;
  logic     q_valid;
  logic     q_ready;
  op_t      q_op;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  csh_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .chunk_bytes (chunk_bytes),
    .byte_count  (byte_count),
    .first       (first),
    .last        (last),
    .seed        (seed),
    .op_valid    (f_valid),
    .op_ready    (q_in_ready),
    .op          (f_op)
  );

  csh_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (q_in_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  csh_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  csh_back u_back (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (q_valid),
    .op_ready   (q_ready),
    .op         (q_op),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

  a_mul_no_overlap: assert property (@(posedge clk) disable iff (rst)
    mul_req.start |-> !mul_rsp.busy)
    else $error("multiplier started while busy");

  a_mul_done_pulse: assert property (@(posedge clk) disable iff (rst)
    mul_rsp.done |=> !mul_rsp.done)
    else $error("multiplier done held for more than one cycle");

  a_front_hold: assert property (@(posedge clk) disable iff (rst)
    (f_valid && !q_in_ready) |=> f_valid && $stable(f_op))
    else $error("input stage dropped an item while the queue was full");

endmodule

>>> rtl/csh_front.sv
// Input stage: takes chunk transfers, masks the chunk and classifies the item.
module csh_front import csh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] chunk_bytes,
  input  logic [3:0]  byte_count,
  input  logic        first,
  input  logic        last,
  input  logic [63:0] seed,
  output logic        op_valid,
  input  logic        op_ready,
  output op_t         op
);

  logic [3:0]  count_clamped;
  logic [63:0] chunk_masked;

  always_comb begin
    count_clamped = (byte_count > 4'(CHUNK_BYTES)) ? 4'(CHUNK_BYTES) : byte_count;
    for (int k = 0; k < CHUNK_BYTES; k++) begin
      chunk_masked[8*k +: 8] = (4'(k) < count_clamped) ? chunk_bytes[8*k +: 8] : 8'd0;
    end
  end

  assign in_ready = !op_valid || op_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else if (in_ready) begin
      op_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op.chunk <= chunk_masked;
      op.mix   <= |byte_count;
      op.first <= first;
      op.last  <= last;
      op.seed  <= seed;
    end
  end

endmodule

>>> rtl/csh_queue.sv
// Short queue of classified items between the input stage and the hash engine.
module csh_queue import csh_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_op,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_op     = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

endmodule

>>> rtl/csh_mul.sv
// Iterative 64x64 low-half multiplier built from one shared 32x32 multiplier.
module csh_mul import csh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic [1:0] STEP_LO_LO = 2'd0;
  localparam logic [1:0] STEP_LO_HI = 2'd1;
  localparam logic [1:0] STEP_HI_LO = 2'd2;

  logic [63:0] op_a;
  logic [63:0] op_b;
  logic [63:0] acc;
  logic [1:0]  step;
  logic        busy;
  logic        done;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] prod;

  always_comb begin
    unique case (step)
      STEP_LO_LO: begin
        mul_x = op_a[31:0];
        mul_y = op_b[31:0];
      end
      STEP_LO_HI: begin
        mul_x = op_a[31:0];
        mul_y = op_b[63:32];
      end
      STEP_HI_LO: begin
        mul_x = op_a[63:32];
        mul_y = op_b[31:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    prod = 64'(mul_x) * 64'(mul_y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= STEP_LO_LO;
    end else begin
      done <= busy && (step == STEP_HI_LO);
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_LO_LO;
      end else if (busy) begin
        if (step == STEP_HI_LO) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_a <= req.a;
      op_b <= req.b;
    end else if (busy) begin
      if (step == STEP_LO_LO) begin
        acc <= prod;
      end else begin
        acc <= acc + {prod[31:0], 32'd0};
      end
    end
  end

  assign rsp.busy    = busy;
  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

>>> rtl/csh_back.sv
// Hash engine: lane updates, finalization sequence and result register.
module csh_back import csh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        op_valid,
  output logic        op_ready,
  input  op_t         op,
  output mul_req_t    mul_req,
  input  mul_rsp_t    mul_rsp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MIX  = 3'd1;
  localparam logic [2:0] ST_FA   = 3'd2;
  localparam logic [2:0] ST_FB   = 3'd3;
  localparam logic [2:0] ST_M1   = 3'd4;
  localparam logic [2:0] ST_M2   = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0]  state;
  logic [63:0] lane_one;
  logic [63:0] lane_two;
  logic        last_pend;
  logic [63:0] fin_a;
  logic [63:0] fin_b;
  logic [63:0] fmix_a;
  logic [63:0] fin_sum;
  logic        second;
  logic        pop;
  logic [63:0] mix_in;
  logic [63:0] mixed;
  logic [63:0] p_fold;

  assign op_ready = state == ST_IDLE;
  assign pop      = op_valid && op_ready;
  assign mix_in   = (op.first ? op.seed + GOLDEN_MUL : lane_one) ^ op.chunk;
  assign mixed    = mul_rsp.product ^ (mul_rsp.product >> MIX_SHIFT);
  assign p_fold   = mul_rsp.product ^ (mul_rsp.product >> FMIX_SHIFT);

  always_comb begin
    mul_req.start = 1'b0;
    mul_req.a     = '0;
    mul_req.b     = '0;
    unique case (state)
      ST_IDLE: begin
        if (pop && op.mix) begin
          mul_req.start = 1'b1;
          mul_req.a     = mix_in;
          mul_req.b     = GOLDEN_MUL;
        end
      end
      ST_FB: begin
        mul_req.start = 1'b1;
        mul_req.a     = fin_a ^ (fin_a >> FMIX_SHIFT);
        mul_req.b     = FMIX_MUL_A;
      end
      ST_M1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = p_fold;
          mul_req.b     = FMIX_MUL_B;
        end
      end
      ST_M2: begin
        if (mul_rsp.done && !second) begin
          mul_req.start = 1'b1;
          mul_req.a     = fin_b ^ (fin_b >> FMIX_SHIFT);
          mul_req.b     = FMIX_MUL_A;
        end
      end
      default: begin
        mul_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      lane_one  <= '0;
      lane_two  <= '0;
      last_pend <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            last_pend <= op.last;
            if (op.first) begin
              lane_one <= op.seed + GOLDEN_MUL;
              lane_two <= op.seed - SEED_SUB;
            end
            if (op.mix) begin
              state <= ST_MIX;
            end else if (op.last) begin
              state <= ST_FA;
            end
          end
        end
        ST_MIX: begin
          if (mul_rsp.done) begin
            lane_one <= mixed;
            lane_two <= lane_two + mixed;
            state    <= last_pend ? ST_FA : ST_IDLE;
          end
        end
        ST_FA: begin
          fin_a <= lane_one + lane_two;
          state <= ST_FB;
        end
        ST_FB: begin
          fin_b  <= lane_two + fin_a;
          second <= 1'b0;
          state  <= ST_M1;
        end
        ST_M1: begin
          if (mul_rsp.done) begin
            state <= ST_M2;
          end
        end
        ST_M2: begin
          if (mul_rsp.done) begin
            if (!second) begin
              fmix_a <= p_fold;
              second <= 1'b1;
              state  <= ST_M1;
            end else begin
              fin_sum <= fmix_a + p_fold;
              state   <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            hash_value <= fin_sum;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
